### hdl/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the ADTS frame splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package afs_pkg;

  localparam int HdrLen    = 7;
  localparam int HdrHeld   = 6;
  localparam int QueDepth  = 8;
  localparam int QuePtrW   = $clog2(QueDepth);
  localparam int QueCntW   = $clog2(QueDepth + 1);
  localparam int LenW      = 13;

  localparam logic [LenW-1:0] HdrLenVal = LenW'(HdrLen);

  // one command from the front end to the back end
  typedef struct packed {
    logic                  is_hdr;
    logic [HdrHeld-1:0][7:0] hdr_bytes;
    logic [7:0]            last_byte;
    logic                  end_flag;
    logic [LenW-1:0]       len;
    logic [1:0]            prof;
    logic [3:0]            rate;
    logic [2:0]            chan;
  } afs_cmd_t;

endpackage

`default_nettype wire

### hdl/adts_frame_splitter_unit.sv
// ----------------------------------------------------------------------------
// adts_frame_splitter_unit
// ADTS byte stream deframer: header capture, decode and byte pass-through.
// ----------------------------------------------------------------------------
// throughput: one input byte per cycle while full is low, one result per
// cycle sustained while pop keeps up; each command passes the queue and
// then the output register; payload behind a header waits for its results
// the seven header results leave one by one, stepped by the back end counter
// an eight-entry command queue absorbs the payload that arrives during a burst
// reset: synchronous; counters, queue pointers and output header fields clear
`default_nettype none

module adts_frame_splitter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             frame_start,
  output logic             frame_end,
  output logic [12:0]      frame_length,
  output logic [2:0]       profile_plus_one,
  output logic [3:0]       rate_index,
  output logic [2:0]       channel_config,
  output logic [7:0]       asc_first,
  output logic [7:0]       asc_second,
  output logic             length_error
);
  import afs_pkg::*;

  afs_cmd_t  front_cmd;
  afs_cmd_t  head_cmd;
  logic      front_valid;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  afs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .cmd       (front_cmd),
    .cmd_valid (front_valid)
  );

  afs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_cmd  (front_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_cmd  (head_cmd),
    .q_valid (q_valid)
  );

  afs_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head_cmd),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .pop              (pop),
    .empty            (empty),
    .out_byte         (out_byte),
    .frame_start      (frame_start),
    .frame_end        (frame_end),
    .frame_length     (frame_length),
    .profile_plus_one (profile_plus_one),
    .rate_index       (rate_index),
    .channel_config   (channel_config),
    .asc_first        (asc_first),
    .asc_second       (asc_second),
    .length_error     (length_error)
  );

endmodule

`default_nettype wire

### hdl/afs_front.sv
// ----------------------------------------------------------------------------
// afs_front
// Collects header bytes, decodes the header and counts payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module afs_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  output afs_pkg::afs_cmd_t      cmd,
  output logic                   cmd_valid
);
  import afs_pkg::*;

  logic [2:0]                  hdr_count;
  logic [2:0]                  hdr_count_next;
  logic [LenW-1:0]             bytes_left;
  logic [LenW-1:0]             bytes_left_next;
  logic [HdrHeld-1:0][7:0]     hdr_bytes;
  logic                        in_payload;
  logic                        hdr_done;
  logic [LenW-1:0]             len;

  assign in_payload = (bytes_left != '0);
  assign hdr_done   = (hdr_count == 3'(HdrHeld));

  assign len = {hdr_bytes[3][1:0], hdr_bytes[4], hdr_bytes[5][7:5]};

  always_comb begin
    cmd.is_hdr    = !in_payload;
    cmd.hdr_bytes = hdr_bytes;
    cmd.last_byte = data_byte;
    cmd.len       = len;
    cmd.prof      = hdr_bytes[2][7:6];
    cmd.rate      = hdr_bytes[2][5:2];
    cmd.chan      = {hdr_bytes[2][0], hdr_bytes[3][7:6]};
    if (in_payload) begin
      cmd.end_flag = (bytes_left == LenW'(1));
    end else begin
      cmd.end_flag = (len <= HdrLenVal);
    end
    cmd_valid = accept && (in_payload || hdr_done);

    hdr_count_next  = hdr_count;
    bytes_left_next = bytes_left;
    if (accept) begin
      priority if (in_payload) begin
        bytes_left_next = bytes_left - LenW'(1);
      end else if (!hdr_done) begin
        hdr_count_next = hdr_count + 3'd1;
      end else begin
        hdr_count_next  = '0;
        bytes_left_next = (len > HdrLenVal) ? (len - HdrLenVal) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_count  <= '0;
      bytes_left <= '0;
    end else begin
      hdr_count  <= hdr_count_next;
      bytes_left <= bytes_left_next;
    end
  end

  // header byte store, first six header bytes only
  always_ff @(posedge clk) begin
    if (accept && !in_payload && !hdr_done) begin
      hdr_bytes[hdr_count] <= data_byte;
    end
  end

endmodule

`default_nettype wire

### hdl/afs_queue.sv
// ----------------------------------------------------------------------------
// afs_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module afs_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  afs_pkg::afs_cmd_t      wr_cmd,
  output logic                   q_full,
  input  wire logic              rd_en,
  output afs_pkg::afs_cmd_t      rd_cmd,
  output logic                   q_valid
);
  import afs_pkg::*;

  afs_cmd_t               entries [QueDepth];
  logic [QuePtrW-1:0]     wptr;
  logic [QuePtrW-1:0]     rptr;
  logic [QueCntW-1:0]     count;

  assign q_full  = (count == QueCntW'(QueDepth));
  assign q_valid = (count != '0);
  assign rd_cmd  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + QuePtrW'(1);
      end
      if (rd_en) begin
        rptr <= rptr + QuePtrW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + QueCntW'(1);
        2'b01:   count <= count - QueCntW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

### hdl/afs_back.sv
// ----------------------------------------------------------------------------
// afs_back
// Expands commands into result bytes and holds the current header fields.
// ----------------------------------------------------------------------------
`default_nettype none

module afs_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  afs_pkg::afs_cmd_t      head,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [7:0]             out_byte,
  output logic                   frame_start,
  output logic                   frame_end,
  output logic [12:0]            frame_length,
  output logic [2:0]             profile_plus_one,
  output logic [3:0]             rate_index,
  output logic [2:0]             channel_config,
  output logic [7:0]             asc_first,
  output logic [7:0]             asc_second,
  output logic                   length_error
);
  import afs_pkg::*;

  logic            out_valid;
  logic [2:0]      slot;
  logic [2:0]      slot_next;
  logic            load;
  logic            last_slot;
  logic [7:0]      sel_byte;
  logic            asc_latched;
  logic [2:0]      new_prof1;

  assign empty     = !out_valid;
  assign load      = q_valid && (!out_valid || pop);
  assign last_slot = (slot == 3'(HdrHeld));
  assign new_prof1 = {1'b0, head.prof} + 3'd1;

  always_comb begin
    sel_byte  = head.last_byte;
    slot_next = slot;
    q_pop     = 1'b0;
    if (head.is_hdr && !last_slot) begin
      sel_byte = head.hdr_bytes[slot];
    end
    if (load) begin
      if (head.is_hdr) begin
        slot_next = last_slot ? '0 : slot + 3'd1;
        q_pop     = last_slot;
      end else begin
        q_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      slot             <= '0;
      asc_latched      <= 1'b0;
      frame_length     <= '0;
      profile_plus_one <= 3'd1;
      rate_index       <= '0;
      channel_config   <= '0;
      asc_first        <= '0;
      asc_second       <= '0;
    end else begin
      slot <= slot_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      // new header takes effect with its first byte
      if (load && head.is_hdr && (slot == '0)) begin
        frame_length     <= head.len;
        profile_plus_one <= new_prof1;
        rate_index       <= head.rate;
        channel_config   <= head.chan;
        if (!asc_latched) begin
          asc_latched <= 1'b1;
          asc_first   <= {2'b00, new_prof1, head.rate[3:1]};
          asc_second  <= {head.rate[0], 1'b0, head.chan, 3'b000};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= sel_byte;
      frame_start <= head.is_hdr && (slot == '0);
      frame_end   <= head.end_flag && (!head.is_hdr || last_slot);
    end
  end

  assign length_error = (frame_length < HdrLenVal);

endmodule

`default_nettype wire
